>>> hw/rtl/event_watcher_fanout_table_defines.svh
// Assertion macros for the event watcher fan-out table.
// Included by the RTL files that carry concurrent assertions; depends on nothing.
`ifndef EVENT_WATCHER_FANOUT_TABLE_DEFINES_SVH
`define EVENT_WATCHER_FANOUT_TABLE_DEFINES_SVH

// check a condition at every clock edge outside reset
`define EWFT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a trigger implies a condition in the next cycle
`define EWFT_ASSERT_NEXT(label, clk, rst_n, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error(msg);

`endif

>>> hw/rtl/ewft_pkg.sv
// Shared types and codes for the event watcher fan-out table.
// Used by the top level; depends on nothing.
package ewft_pkg;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_NOTIFY = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    RK_DONE   = 2'd0,
    RK_REJECT = 2'd1,
    RK_SIGNAL = 2'd2,
    RK_NONE   = 2'd3
  } result_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NWALK,
    ST_NFIN,
    ST_RWALK,
    ST_RFIN
  } state_e;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] watcher;
  } entry_t;

endpackage

>>> hw/rtl/ewft_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Standalone; depends on nothing.
module ewft_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/event_watcher_fanout_table.sv
// Top level of the event watcher fan-out table: control sequencer and output register.
// Depends on ewft_pkg, ewft_ram and event_watcher_fanout_table_defines.svh.
//
//   channel | direction | handshake             | words per item
//   --------+-----------+-----------------------+---------------------------
//   in      | input     | in_valid_i/in_stall_o | 1
//   out     | output    | out_valid_o/out_stall_i | 1, or 1 per watcher found
//
// Add and clear are done in the cycle they are accepted. Remove and notify walk the
// table RAM one entry a cycle over its one read port. A notify also waits
// whenever the output register is stalled with a signal word ready to follow.
// The table is held oldest first in RAM behind a fill count, so reset and clear
// are immediate, with no clearing pass.
`include "event_watcher_fanout_table_defines.svh"

module event_watcher_fanout_table #(
  parameter int SLOTS       = 16,
  parameter int EVENT_KINDS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [3:0]  event_kind_i,
  input  logic [7:0]  watcher_id_i,
  input  logic [31:0] endpoint_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  signal_watcher_o,
  output logic [31:0] signal_endpoint_o,
  output logic        last_o
);

  import ewft_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int EW = $bits(entry_t);

  state_e       state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] j_q, j_d;
  logic [AW-1:0] idx_q, idx_d;
  logic         pend_q, pend_d;
  logic [7:0]   pend_watcher_q, pend_watcher_d;
  logic [3:0]   ev_q;
  logic [7:0]   wid_q;
  logic [31:0]  ep_q;

  logic         out_valid_q;
  result_kind_e out_kind_q;
  logic [7:0]   out_watcher_q;
  logic [31:0]  out_endpoint_q;
  logic         out_last_q;

  logic         emit;
  result_kind_e e_kind;
  logic [7:0]   e_watcher;
  logic [31:0]  e_endpoint;
  logic         e_last;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  entry_t        rd;

  logic          out_free, in_accept, ev_ok, match, keep;
  logic [CW-1:0] count_m1;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_accept = in_valid_i && !in_stall_o;
  assign ev_ok     = {1'b0, event_kind_i} < 5'(EVENT_KINDS);
  assign count_m1  = count_q - CW'(1);
  assign rd        = entry_t'(ram_rdata);
  assign match     = rd.kind == ev_q;
  assign keep      = rd.watcher != wid_q;

  ewft_ram #(
    .WIDTH(EW),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    idx_d          = idx_q;
    j_d            = j_q;
    pend_d         = pend_q;
    pend_watcher_d = pend_watcher_q;
    emit           = 1'b0;
    e_kind         = RK_DONE;
    e_watcher      = '0;
    e_endpoint     = '0;
    e_last         = 1'b1;
    ram_we         = 1'b0;
    ram_waddr      = j_q[AW-1:0];
    ram_wdata      = rd;
    ram_re         = 1'b0;
    ram_raddr      = idx_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (action_e'(action_i))
            ACT_ADD: begin
              emit = 1'b1;
              if (ev_ok && (count_q < CW'(SLOTS))) begin
                ram_we    = 1'b1;
                ram_waddr = count_q[AW-1:0];
                ram_wdata = entry_t'{kind: event_kind_i, watcher: watcher_id_i};
                count_d   = count_q + CW'(1);
              end else begin
                e_kind = RK_REJECT;
              end
            end
            ACT_REMOVE: begin
              if (count_q == '0) begin
                emit = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                idx_d     = '0;
                j_d       = '0;
                state_d   = ST_RWALK;
              end
            end
            ACT_NOTIFY: begin
              if (!ev_ok || (count_q == '0)) begin
                emit   = 1'b1;
                e_kind = RK_NONE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = count_m1[AW-1:0];
                idx_d     = count_m1[AW-1:0];
                pend_d    = 1'b0;
                state_d   = ST_NWALK;
              end
            end
            ACT_CLEAR: begin
              count_d = '0;
              emit    = 1'b1;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_NWALK: begin
        if (!(match && pend_q && !out_free)) begin
          if (match) begin
            if (pend_q) begin
              emit       = 1'b1;
              e_kind     = RK_SIGNAL;
              e_watcher  = pend_watcher_q;
              e_endpoint = ep_q;
              e_last     = 1'b0;
            end
            pend_d         = 1'b1;
            pend_watcher_d = rd.watcher;
          end
          if (idx_q == '0) begin
            state_d = ST_NFIN;
          end else begin
            idx_d     = idx_q - AW'(1);
            ram_re    = 1'b1;
            ram_raddr = idx_q - AW'(1);
          end
        end
      end
      ST_NFIN: begin
        if (out_free) begin
          emit = 1'b1;
          if (pend_q) begin
            e_kind     = RK_SIGNAL;
            e_watcher  = pend_watcher_q;
            e_endpoint = ep_q;
          end else begin
            e_kind = RK_NONE;
          end
          pend_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end
      ST_RWALK: begin
        if (keep) begin
          ram_we    = 1'b1;
          ram_waddr = j_q[AW-1:0];
          ram_wdata = rd;
          j_d       = j_q + CW'(1);
        end
        if (CW'(idx_q) == count_m1) begin
          count_d = keep ? j_q + CW'(1) : j_q;
          state_d = ST_RFIN;
        end else begin
          idx_d     = idx_q + AW'(1);
          ram_re    = 1'b1;
          ram_raddr = idx_q + AW'(1);
        end
      end
      ST_RFIN: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      j_q         <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      j_q     <= j_d;
      pend_q  <= pend_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_watcher_q <= pend_watcher_d;
    if (in_accept) begin
      ev_q  <= event_kind_i;
      wid_q <= watcher_id_i;
      ep_q  <= endpoint_id_i;
    end
    if (emit) begin
      out_kind_q     <= e_kind;
      out_watcher_q  <= e_watcher;
      out_endpoint_q <= e_endpoint;
      out_last_q     <= e_last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_kind_o     = out_kind_q;
  assign signal_watcher_o  = out_watcher_q;
  assign signal_endpoint_o = out_endpoint_q;
  assign last_o            = out_last_q;

  `EWFT_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(SLOTS), "fill count above table size")
  `EWFT_ASSERT(a_emit_free, clk_i, rst_ni, !emit || out_free, "result loaded into busy register")
  `EWFT_ASSERT(a_compact_behind, clk_i, rst_ni,
    !(state_q == ST_RWALK && ram_we) || (CW'(idx_q) >= j_q), "compaction write ahead of read")
  `EWFT_ASSERT_NEXT(a_last_idle, clk_i, rst_ni, emit && e_last, state_q == ST_IDLE,
    "sequencer busy after final word")

endmodule

>>> verif/tb.sv
// Self-checking testbench for event_watcher_fanout_table: directed table, then random traffic.
// Depends on ewft_pkg and the RTL top level; predicts every result word from its own table copy.
module tb;
  import ewft_pkg::*;

  localparam int SLOTS       = 16;
  localparam int EVENT_KINDS = 4;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 21;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    result_kind_e kind;
    logic [7:0]   watcher;
    logic [31:0]  endpoint;
    logic         last;
  } word_t;

  typedef struct {
    action_e      act;
    logic [3:0]   ev;
    logic [7:0]   wid;
    logic [31:0]  ep;
    bit           typed;
    result_kind_e want;
  } row_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i      = '0;
  logic [3:0]  event_kind_i  = '0;
  logic [7:0]  watcher_id_i  = '0;
  logic [31:0] endpoint_id_i = '0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [1:0]  result_kind_o;
  logic [7:0]  signal_watcher_o;
  logic [31:0] signal_endpoint_o;
  logic        last_o;

  entry_t watch_table[$];
  word_t  due_words[$];
  row_t   directed_rows[$];
  logic [7:0] wid_pool[8];

  int cycles;
  int fails;
  int items_sent;
  int words_checked;
  int signals_seen;
  int full_rejects;
  int range_rejects;
  int empty_notifies;
  bit quiet_in;
  bit quiet_out;

  event_watcher_fanout_table #(
    .SLOTS      (SLOTS),
    .EVENT_KINDS(EVENT_KINDS)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .event_kind_i     (event_kind_i),
    .watcher_id_i     (watcher_id_i),
    .endpoint_id_i    (endpoint_id_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_kind_o    (result_kind_o),
    .signal_watcher_o (signal_watcher_o),
    .signal_endpoint_o(signal_endpoint_o),
    .last_o           (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycles <= cycles + 1;

  task automatic due_word(result_kind_e kind, logic [7:0] watcher, logic [31:0] endpoint,
                          logic last);
    word_t w;
    w.kind     = kind;
    w.watcher  = watcher;
    w.endpoint = endpoint;
    w.last     = last;
    due_words.push_back(w);
  endtask

  task automatic apply_to_table(row_t r);
    entry_t e;
    word_t  w;
    int     i;
    int     hits;
    case (r.act)
      ACT_ADD: begin
        if (r.ev >= EVENT_KINDS || watch_table.size() >= SLOTS) begin
          if (r.ev >= EVENT_KINDS) range_rejects++;
          else full_rejects++;
          due_word(RK_REJECT, '0, '0, 1'b1);
        end else begin
          e.kind    = r.ev;
          e.watcher = r.wid;
          watch_table.push_front(e);
          due_word(RK_DONE, '0, '0, 1'b1);
        end
      end
      ACT_REMOVE: begin
        for (i = watch_table.size() - 1; i >= 0; i--) begin
          if (watch_table[i].watcher == r.wid) watch_table.delete(i);
        end
        due_word(RK_DONE, '0, '0, 1'b1);
      end
      ACT_NOTIFY: begin
        hits = 0;
        if (r.ev < EVENT_KINDS) begin
          for (i = 0; i < watch_table.size(); i++) begin
            if (watch_table[i].kind == r.ev) begin
              due_word(RK_SIGNAL, watch_table[i].watcher, r.ep, 1'b0);
              hits++;
            end
          end
        end
        if (hits == 0) begin
          empty_notifies++;
          due_word(RK_NONE, '0, '0, 1'b1);
        end else begin
          w = due_words.pop_back();
          w.last = 1'b1;
          due_words.push_back(w);
        end
      end
      default: begin
        watch_table.delete();
        due_word(RK_DONE, '0, '0, 1'b1);
      end
    endcase
  endtask

  task automatic push_word(row_t r);
    int gap;
    int queued;
    gap = quiet_in ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= r.act;
    event_kind_i  <= r.ev;
    watcher_id_i  <= r.wid;
    endpoint_id_i <= r.ep;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    queued = due_words.size();
    apply_to_table(r);
    if (r.typed) begin
      while (due_words.size() > queued) void'(due_words.pop_back());
      due_word(r.want, '0, '0, 1'b1);
    end
    items_sent++;
  endtask

  task automatic add_row(action_e act, logic [3:0] ev, logic [7:0] wid, logic [31:0] ep,
                         bit typed, result_kind_e want);
    row_t r;
    r.act   = act;
    r.ev    = ev;
    r.wid   = wid;
    r.ep    = ep;
    r.typed = typed;
    r.want  = want;
    directed_rows.push_back(r);
  endtask

  // receive side: stall a random number of cycles before each word
  initial begin : drain_side
    int gap;
    int seen;
    seen = 0;
    @(posedge rst_ni);
    forever begin
      if (seen % 16 == 0) quiet_out = ($urandom_range(0, 3) == 0);
      gap = quiet_out ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
      while (!(out_valid_o && !out_stall_i)) @(posedge clk_i);
      seen++;
    end
  end

  always @(posedge clk_i) begin : check_out
    word_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_words.size() == 0) begin
        $error("unexpected word: kind %0d watcher %0h endpoint %0h last %0b",
               result_kind_o, signal_watcher_o, signal_endpoint_o, last_o);
        fails++;
      end else begin
        w = due_words.pop_front();
        words_checked++;
        if (result_kind_o == RK_SIGNAL) signals_seen++;
        if (result_kind_o !== w.kind) begin
          $error("result_kind: expected %0d, got %0d", w.kind, result_kind_o);
          fails++;
        end
        if (signal_watcher_o !== w.watcher) begin
          $error("signal_watcher: expected %0h, got %0h", w.watcher, signal_watcher_o);
          fails++;
        end
        if (signal_endpoint_o !== w.endpoint) begin
          $error("signal_endpoint: expected %0h, got %0h", w.endpoint, signal_endpoint_o);
          fails++;
        end
        if (last_o !== w.last) begin
          $error("last: expected %0b, got %0b", w.last, last_o);
          fails++;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) @(posedge clk_i);
    $display("tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    row_t r;
    int   k;
    int   p;
    int   roll;
    int   mode;
    cycles         = 0;
    fails          = 0;
    items_sent     = 0;
    words_checked  = 0;
    signals_seen   = 0;
    full_rejects   = 0;
    range_rejects  = 0;
    empty_notifies = 0;
    quiet_in       = 1'b0;
    quiet_out      = 1'b0;

    wid_pool[0] = 8'h00;
    wid_pool[1] = 8'hFF;
    for (k = 2; k < 8; k++) wid_pool[k] = 8'($urandom);

    add_row(ACT_NOTIFY, 4'd0, 8'h00, 32'h0000_0001, 1'b1, RK_NONE);
    add_row(ACT_REMOVE, 4'd0, 8'h00, 32'h0, 1'b1, RK_DONE);
    add_row(ACT_ADD, 4'(EVENT_KINDS), 8'h11, 32'h0, 1'b1, RK_REJECT);
    for (k = 0; k < SLOTS; k++) begin
      add_row(ACT_ADD, 4'(k % EVENT_KINDS),
              (k == 0 || k == 2) ? 8'h00 : (k == 1 || k == SLOTS - 1) ? 8'hFF : 8'(8'h10 + k),
              32'h0, 1'b1, RK_DONE);
    end
    add_row(ACT_ADD, 4'd1, 8'h33, 32'h0, 1'b1, RK_REJECT);
    add_row(ACT_NOTIFY, 4'd0, 8'h00, 32'hFFFF_FFFF, 1'b0, RK_NONE);
    add_row(ACT_NOTIFY, 4'(EVENT_KINDS - 1), 8'h00, 32'h0000_0000, 1'b0, RK_NONE);
    add_row(ACT_REMOVE, 4'd0, 8'hFF, 32'h0, 1'b1, RK_DONE);
    add_row(ACT_NOTIFY, 4'hF, 8'hFF, 32'hA5A5_5A5A, 1'b1, RK_NONE);
    add_row(ACT_CLEAR, 4'd0, 8'h00, 32'h0, 1'b1, RK_DONE);
    add_row(ACT_NOTIFY, 4'd0, 8'h00, 32'h1234_5678, 1'b1, RK_NONE);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) push_word(directed_rows[k]);

    // phases rotate between filling, mixed traffic and draining
    for (p = 0; p < PHASES; p++) begin
      mode     = p % 3;
      quiet_in = ($urandom_range(0, 3) == 0);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        case (mode)
          0:       r.act = roll < 70 ? ACT_ADD : roll < 90 ? ACT_NOTIFY :
                           roll < 98 ? ACT_REMOVE : ACT_CLEAR;
          1:       r.act = roll < 40 ? ACT_ADD : roll < 75 ? ACT_NOTIFY :
                           roll < 95 ? ACT_REMOVE : ACT_CLEAR;
          default: r.act = roll < 25 ? ACT_ADD : roll < 70 ? ACT_NOTIFY :
                           roll < 95 ? ACT_REMOVE : ACT_CLEAR;
        endcase
        r.ev    = ($urandom_range(0, 9) != 0) ? 4'($urandom_range(0, EVENT_KINDS - 1))
                                              : 4'($urandom_range(EVENT_KINDS, 15));
        r.wid   = ($urandom_range(0, 4) != 0) ? wid_pool[$urandom_range(0, 7)] : 8'($urandom);
        r.ep    = $urandom;
        r.typed = 1'b0;
        r.want  = RK_DONE;
        push_word(r);
      end
    end
    in_valid_i <= 1'b0;

    while (due_words.size() != 0) @(posedge clk_i);
    repeat (SLOTS + 4) @(posedge clk_i);

    $display("tb: %0d items, %0d words checked, %0d signals, %0d empty notifies",
             items_sent, words_checked, signals_seen, empty_notifies);
    $display("tb: adds rejected for full table %0d, for event out of range %0d",
             full_rejects, range_rejects);
    if (fails == 0 && due_words.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
